@@ design/sbe_pkg.sv @@
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared constants, opcode, error and status codes of the bytecode executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

    localparam int unsigned STACK_DEPTH = 1024;
    localparam int unsigned REG_COUNT   = 4;

    localparam int unsigned SADDR_W    = $clog2(STACK_DEPTH);
    localparam int unsigned SCNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int unsigned REG_W      = $clog2(REG_COUNT);
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned PC_W       = 16;
    localparam int unsigned CMD_W      = 5;
    localparam int unsigned OPND_W     = 32;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_CNT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        OP_PRINT   = 5'd0,
        OP_ADD     = 5'd1,
        OP_SUB     = 5'd2,
        OP_MUL     = 5'd3,
        OP_DIV     = 5'd4,
        OP_PUSHC   = 5'd5,
        OP_POP     = 5'd6,
        OP_RESERVE = 5'd7,
        OP_STORE   = 5'd8,
        OP_LOAD    = 5'd9,
        OP_JMP     = 5'd10,
        OP_CALL    = 5'd11,
        OP_RET     = 5'd12,
        OP_PUSHR   = 5'd13,
        OP_POPR    = 5'd14,
        OP_LOADR   = 5'd15,
        OP_STORER  = 5'd16,
        OP_HALT    = 5'd17
    } t_op;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_UNDERFLOW = 4'd1,
        ERR_DIV_ZERO  = 4'd2,
        ERR_MISSING   = 4'd3,
        ERR_CONST     = 4'd4,
        ERR_OFFSET    = 4'd5,
        ERR_REG       = 4'd6,
        ERR_TARGET    = 4'd7,
        ERR_OPCODE    = 4'd8,
        ERR_OVERFLOW  = 4'd9
    } t_err;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_HALTED   = 2'd1,
        ST_PAST_END = 2'd2,
        ST_ERROR    = 2'd3
    } t_status;

endpackage

`default_nettype wire

@@ design/sbe_in_if.sv @@
// ----------------------------------------------------------------------------
// sbe_in_if
// Instruction item channel: opcode, operand words and resolved constant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbe_in_if;
    import sbe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [OPND_W-1:0]        operand_a;
    logic signed [OPND_W-1:0] operand_b;
    logic [WORD_W-1:0]        constant_value;

    modport source (output valid, cmd, operand_a, operand_b, constant_value, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, constant_value, output ready);
endinterface

`default_nettype wire

@@ design/sbe_out_if.sv @@
// ----------------------------------------------------------------------------
// sbe_out_if
// Result item channel: next fetch address, run status and printed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbe_out_if;
    import sbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [PC_W-1:0]   next_pc;
    logic [1:0]        run_status;
    logic [3:0]        error_code;
    logic              print_valid;
    logic [WORD_W-1:0] print_value;

    modport source (output valid, next_pc, run_status, error_code, print_valid, print_value,
                    input ready);
    modport sink   (input valid, next_pc, run_status, error_code, print_valid, print_value,
                    output ready);
endinterface

`default_nettype wire

@@ design/stack_bytecode_executor_core.sv @@
// ----------------------------------------------------------------------------
// stack_bytecode_executor_core
// Executes one stack-machine instruction per item against a stack RAM and a
// small register file; reports next fetch address, run status and prints.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_item    in   valid/ready    cmd, operand_a, operand_b, constant_value
//  o_result  out  valid/ready    next_pc, run_status, error_code, print_*
//  i_cfg_*   in   write enable   program_length, constant_count
//
//  Per item: add/sub read two stack words; mul uses one shared 32x32
//  multiplier for three partial products; div finds one quotient bit per
//  cycle; reserve writes one zero word per cycle; ret makes three stack
//  reads, one after another.
//  A new item is taken once the previous result has left the output register.
//  Reset is synchronous; no clearing pass: a high-water mark masks stack
//  words never written, which read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stack_bytecode_executor_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    sbe_in_if.sink                              i_item,
    sbe_out_if.source                           o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sbe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sbe_pkg::*;

    localparam int unsigned Q_W = OPND_W - 3;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RD1, S_RD2, S_RD3, S_MUL, S_DIV, S_WB, S_FILL, S_CALL2
    } t_state;

    t_state              r_state, n_state;
    logic                r_run, n_run;
    logic [PC_W-1:0]     r_pc, n_pc;
    logic [PC_W-1:0]     r_len, n_len;
    logic [PC_W-1:0]     r_cc, n_cc;
    logic [SCNT_W-1:0]   r_hw, n_hw;
    logic [WORD_W-1:0]   r_regs [REG_COUNT];
    logic [WORD_W-1:0]   n_regs [REG_COUNT];
    t_op                 r_cmd, n_cmd;
    logic [OPND_W-1:0]   r_a, n_a;
    logic                r_bneg, n_bneg;
    logic [Q_W-1:0]      r_bq, n_bq;
    logic [WORD_W-1:0]   r_cv, n_cv;
    logic [WORD_W-1:0]   r_x, n_x;
    logic [WORD_W-1:0]   r_y, n_y;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [5:0]          r_step, n_step;
    logic [SCNT_W-1:0]   r_cnt, n_cnt;
    logic [SADDR_W-1:0]  r_addr, n_addr;
    logic                r_rdz, n_rdz;
    logic                r_ov, n_ov;
    logic [PC_W-1:0]     r_onpc, n_onpc;
    t_status             r_ost, n_ost;
    t_err                r_oerr, n_oerr;
    logic                r_opv, n_opv;
    logic [WORD_W-1:0]   r_oval, n_oval;

    logic                mem_we;
    logic [SADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [WORD_W-1:0]   mem_wdata, mem_q, rd;

    sbe_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_q)
    );

    assign rd = r_rdz ? '0 : mem_q;

    // Operand and bound checks
    logic [WORD_W-1:0]  sp, fp, hw64, room, base, m_sum, m_diff, q64, reg_a;
    logic [SADDR_W-1:0] sp_lo, fp_lo, m_addr;
    logic               has1, has2, sp_gt_d, sp_ge_d, sp_gt_d2, a_ge_len, a_ge_cc, a_ge_rc;
    logic               slots_nz, res_ovf, m_ok, m_neg, rel_op;
    logic [Q_W-1:0]     slots;
    logic [OPND_W-1:0]  bmag;
    t_err               e_code;

    assign sp       = r_regs[0];
    assign fp       = r_regs[1];
    assign sp_lo    = sp[SADDR_W-1:0];
    assign fp_lo    = fp[SADDR_W-1:0];
    assign hw64     = WORD_W'(r_hw);
    assign reg_a    = r_regs[r_a[REG_W-1:0]];
    assign has1     = ({1'b0, r_pc} + 17'd1) < {1'b0, r_len};
    assign has2     = ({1'b0, r_pc} + 17'd2) < {1'b0, r_len};
    assign sp_gt_d  = sp > WORD_W'(STACK_DEPTH);
    assign sp_ge_d  = sp >= WORD_W'(STACK_DEPTH);
    assign sp_gt_d2 = sp > WORD_W'(STACK_DEPTH - 2);
    assign a_ge_len = r_a >= OPND_W'(r_len);
    assign a_ge_cc  = r_a >= OPND_W'(r_cc);
    assign a_ge_rc  = r_a >= OPND_W'(REG_COUNT);
    assign slots    = r_a[OPND_W-1:3];
    assign slots_nz = slots != '0;
    assign room     = WORD_W'(STACK_DEPTH) - sp;
    assign res_ovf  = slots_nz && (sp_gt_d || WORD_W'(slots) > room);
    assign rel_op   = (r_cmd == OP_LOADR) || (r_cmd == OP_STORER);
    assign base     = rel_op ? reg_a : fp;
    assign m_neg    = rel_op && r_bneg;
    assign q64      = WORD_W'(rel_op ? r_bq : slots);
    assign m_sum    = base + q64;
    assign m_diff   = base - q64;
    assign m_ok     = m_neg ? (base >= q64 && m_diff < hw64)
                            : (base < hw64 && m_sum < hw64);
    assign m_addr   = m_neg ? m_diff[SADDR_W-1:0] : m_sum[SADDR_W-1:0];
    assign bmag     = i_item.operand_b[OPND_W-1] ? (OPND_W'(0) - i_item.operand_b)
                                                 : i_item.operand_b;

    always_comb begin
        e_code = ERR_NONE;
        case (r_cmd)
            OP_PRINT, OP_RET: begin
                if (sp == '0) e_code = ERR_UNDERFLOW;
                else if (sp_gt_d) e_code = ERR_OVERFLOW;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (sp < WORD_W'(2)) e_code = ERR_UNDERFLOW;
                else if (sp_gt_d) e_code = ERR_OVERFLOW;
            end
            OP_PUSHC: begin
                if (!has1) e_code = ERR_MISSING;
                else if (a_ge_cc) e_code = ERR_CONST;
                else if (sp_ge_d) e_code = ERR_OVERFLOW;
            end
            OP_POP: begin
                if (sp == '0) e_code = ERR_UNDERFLOW;
            end
            OP_RESERVE: begin
                if (!has1) e_code = ERR_MISSING;
                else if (res_ovf) e_code = ERR_OVERFLOW;
            end
            OP_STORE: begin
                if (!has1) e_code = ERR_MISSING;
                else if (sp == '0) e_code = ERR_UNDERFLOW;
                else if (!m_ok) e_code = ERR_OFFSET;
                else if (sp_gt_d) e_code = ERR_OVERFLOW;
            end
            OP_LOAD: begin
                if (!has1) e_code = ERR_MISSING;
                else if (!m_ok) e_code = ERR_OFFSET;
                else if (sp_ge_d) e_code = ERR_OVERFLOW;
            end
            OP_JMP: begin
                if (!has1) e_code = ERR_MISSING;
                else if (a_ge_len) e_code = ERR_TARGET;
            end
            OP_CALL: begin
                if (!has1) e_code = ERR_MISSING;
                else if (a_ge_len) e_code = ERR_TARGET;
                else if (sp_gt_d2) e_code = ERR_OVERFLOW;
            end
            OP_PUSHR: begin
                if (!has1) e_code = ERR_MISSING;
                else if (a_ge_rc) e_code = ERR_REG;
                else if (sp_ge_d) e_code = ERR_OVERFLOW;
            end
            OP_POPR: begin
                if (!has1) e_code = ERR_MISSING;
                else if (a_ge_rc) e_code = ERR_REG;
                else if (sp == '0) e_code = ERR_UNDERFLOW;
                else if (sp_gt_d) e_code = ERR_OVERFLOW;
            end
            OP_LOADR: begin
                if (!has2) e_code = ERR_MISSING;
                else if (a_ge_rc) e_code = ERR_REG;
                else if (!m_ok) e_code = ERR_OFFSET;
                else if (sp_ge_d) e_code = ERR_OVERFLOW;
            end
            OP_STORER: begin
                if (!has2) e_code = ERR_MISSING;
                else if (a_ge_rc) e_code = ERR_REG;
                else if (sp == '0) e_code = ERR_UNDERFLOW;
                else if (!m_ok) e_code = ERR_OFFSET;
                else if (sp_gt_d) e_code = ERR_OVERFLOW;
            end
            OP_HALT: e_code = ERR_NONE;
            default: e_code = ERR_OPCODE;
        endcase
    end

    // Shared multiplier and divider step
    logic [31:0]       m_a, m_b;
    logic [63:0]       prod;
    logic [WORD_W:0]   d_sh, d_sub;

    assign m_a   = (r_step == 6'd2) ? r_x[63:32] : r_x[31:0];
    assign m_b   = (r_step == 6'd1) ? r_y[63:32] : r_y[31:0];
    assign prod  = m_a * m_b;
    assign d_sh  = {r_rem, r_x[WORD_W-1]};
    assign d_sub = d_sh - {1'b0, r_y};

    logic            fin, f_halt, f_pe, f_pv;
    t_err            f_err;
    logic [PC_W-1:0] f_npc;
    logic [WORD_W-1:0] f_pval;
    t_status         f_st;

    always_comb begin
        n_state = r_state;  n_run = r_run;   n_pc = r_pc;     n_len = r_len;
        n_cc = r_cc;        n_hw = r_hw;     n_regs = r_regs; n_cmd = r_cmd;
        n_a = r_a;          n_bneg = r_bneg; n_bq = r_bq;     n_cv = r_cv;
        n_x = r_x;          n_y = r_y;       n_rem = r_rem;   n_step = r_step;
        n_cnt = r_cnt;      n_addr = r_addr;
        n_ov = r_ov;        n_onpc = r_onpc; n_ost = r_ost;   n_oerr = r_oerr;
        n_opv = r_opv;      n_oval = r_oval;
        mem_we = 1'b0;      mem_waddr = sp_lo; mem_wdata = '0; mem_raddr = sp_lo - 1'b1;
        fin = 1'b0; f_halt = 1'b0; f_pe = 1'b0; f_pv = 1'b0; f_err = ERR_NONE;
        f_npc = '0; f_pval = '0; f_st = ST_RUNNING;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROG_LEN:  n_len = i_cfg_data;
                CFG_CONST_CNT: n_cc  = i_cfg_data;
                default: ;
            endcase
        end

        if (r_ov && o_result.ready) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid && !r_ov) begin
                    n_cmd   = t_op'(i_item.cmd);
                    n_a     = i_item.operand_a;
                    n_bneg  = i_item.operand_b[OPND_W-1];
                    n_bq    = bmag[OPND_W-1:3];
                    n_cv    = i_item.constant_value;
                    if (!r_run) begin
                        n_run     = 1'b1;
                        n_pc      = '0;
                        n_regs[0] = '0;
                        n_regs[1] = '0;
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_pc >= r_len) begin
                    fin = 1'b1; f_pe = 1'b1;
                end else if (e_code != ERR_NONE) begin
                    fin = 1'b1; f_err = e_code;
                end else begin
                    case (r_cmd)
                        OP_PRINT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_RET, OP_POPR: begin
                            n_state = S_RD1;
                        end
                        OP_STORE, OP_STORER: begin
                            n_addr  = m_addr;
                            n_state = S_RD1;
                        end
                        OP_LOAD, OP_LOADR: begin
                            mem_raddr = m_addr;
                            n_state   = S_RD1;
                        end
                        OP_PUSHC: begin
                            mem_we = 1'b1; mem_wdata = r_cv;
                            n_regs[0] = sp + 1'b1;
                            fin = 1'b1; f_npc = r_pc + 16'd2;
                        end
                        OP_PUSHR: begin
                            mem_we = 1'b1; mem_wdata = reg_a;
                            n_regs[0] = sp + 1'b1;
                            fin = 1'b1; f_npc = r_pc + 16'd2;
                        end
                        OP_POP: begin
                            n_regs[0] = sp - 1'b1;
                            fin = 1'b1; f_npc = r_pc + 16'd1;
                        end
                        OP_RESERVE: begin
                            if (slots_nz) begin
                                n_cnt   = slots[SCNT_W-1:0];
                                n_state = S_FILL;
                            end else begin
                                fin = 1'b1; f_npc = r_pc + 16'd2;
                            end
                        end
                        OP_JMP: begin
                            fin = 1'b1; f_npc = r_a[PC_W-1:0];
                        end
                        OP_CALL: begin
                            mem_we = 1'b1; mem_wdata = WORD_W'(r_pc) + WORD_W'(2);
                            n_state = S_CALL2;
                        end
                        OP_HALT: begin
                            fin = 1'b1; f_halt = 1'b1;
                        end
                        default: begin
                            fin = 1'b1; f_err = ERR_OPCODE;
                        end
                    endcase
                end
            end
            S_RD1: begin
                case (r_cmd)
                    OP_PRINT: begin
                        n_regs[0] = sp - 1'b1;
                        fin = 1'b1; f_pv = 1'b1; f_pval = rd; f_npc = r_pc + 16'd1;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        n_y = rd;
                        if (r_cmd == OP_DIV && rd == '0) begin
                            fin = 1'b1; f_err = ERR_DIV_ZERO;
                        end else begin
                            mem_raddr = sp_lo - 2'd2;
                            n_state   = S_RD2;
                        end
                    end
                    OP_STORE, OP_STORER: begin
                        mem_we = 1'b1; mem_waddr = r_addr; mem_wdata = rd;
                        n_regs[0] = sp - 1'b1;
                        fin = 1'b1;
                        f_npc = r_pc + ((r_cmd == OP_STORER) ? 16'd3 : 16'd2);
                    end
                    OP_LOAD, OP_LOADR: begin
                        mem_we = 1'b1; mem_wdata = rd;
                        n_regs[0] = sp + 1'b1;
                        fin = 1'b1;
                        f_npc = r_pc + ((r_cmd == OP_LOADR) ? 16'd3 : 16'd2);
                    end
                    OP_POPR: begin
                        n_regs[0] = sp - 1'b1;
                        n_regs[r_a[REG_W-1:0]] = rd;
                        fin = 1'b1; f_npc = r_pc + 16'd2;
                    end
                    OP_RET: begin
                        n_y = rd;
                        if (fp == '0) begin
                            fin = 1'b1; f_err = ERR_UNDERFLOW;
                        end else if (fp > WORD_W'(STACK_DEPTH)) begin
                            fin = 1'b1; f_err = ERR_OVERFLOW;
                        end else begin
                            mem_raddr = fp_lo - 1'b1;
                            n_state   = S_RD2;
                        end
                    end
                    default: begin
                        fin = 1'b1; f_err = ERR_OPCODE;
                    end
                endcase
            end
            S_RD2: begin
                case (r_cmd)
                    OP_ADD, OP_SUB: begin
                        mem_we = 1'b1; mem_waddr = sp_lo - 2'd2;
                        mem_wdata = (r_cmd == OP_ADD) ? rd + r_y : rd - r_y;
                        n_regs[0] = sp - 1'b1;
                        fin = 1'b1; f_npc = r_pc + 16'd1;
                    end
                    OP_MUL: begin
                        n_x = rd; n_step = '0; n_state = S_MUL;
                    end
                    OP_DIV: begin
                        n_x = rd; n_rem = '0; n_step = '0; n_state = S_DIV;
                    end
                    OP_RET: begin
                        n_x = rd;
                        if (fp == WORD_W'(1)) begin
                            fin = 1'b1; f_err = ERR_UNDERFLOW;
                        end else begin
                            mem_raddr = fp_lo - 2'd2;
                            n_state   = S_RD3;
                        end
                    end
                    default: begin
                        fin = 1'b1; f_err = ERR_OPCODE;
                    end
                endcase
            end
            S_RD3: begin
                if (rd >= WORD_W'(r_len)) begin
                    fin = 1'b1; f_err = ERR_TARGET;
                end else begin
                    mem_we = 1'b1; mem_waddr = fp_lo - 2'd2; mem_wdata = r_y;
                    n_regs[0] = fp - 1'b1;
                    n_regs[1] = r_x;
                    fin = 1'b1; f_npc = rd[PC_W-1:0];
                end
            end
            S_MUL: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    6'd0: n_rem = prod;
                    6'd1: n_rem = r_rem + {prod[31:0], 32'b0};
                    default: begin
                        n_x     = r_rem + {prod[31:0], 32'b0};
                        n_state = S_WB;
                    end
                endcase
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (!d_sub[WORD_W]) begin
                    n_rem = d_sub[WORD_W-1:0];
                    n_x   = {r_x[WORD_W-2:0], 1'b1};
                end else begin
                    n_rem = d_sh[WORD_W-1:0];
                    n_x   = {r_x[WORD_W-2:0], 1'b0};
                end
                if (r_step == 6'd63) n_state = S_WB;
            end
            S_WB: begin
                mem_we = 1'b1; mem_waddr = sp_lo - 2'd2; mem_wdata = r_x;
                n_regs[0] = sp - 1'b1;
                fin = 1'b1; f_npc = r_pc + 16'd1;
            end
            S_FILL: begin
                mem_we = 1'b1; mem_wdata = '0;
                n_regs[0] = sp + 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == SCNT_W'(1)) begin
                    fin = 1'b1; f_npc = r_pc + 16'd2;
                end
            end
            S_CALL2: begin
                mem_we = 1'b1; mem_waddr = sp_lo + 1'b1; mem_wdata = fp;
                n_regs[0] = sp + WORD_W'(2);
                n_regs[1] = sp + WORD_W'(2);
                fin = 1'b1; f_npc = r_a[PC_W-1:0];
            end
            default: n_state = S_IDLE;
        endcase

        if (mem_we && SCNT_W'(mem_waddr) >= r_hw) begin
            n_hw = SCNT_W'(mem_waddr) + 1'b1;
        end
        n_rdz = SCNT_W'(mem_raddr) >= r_hw;

        if (fin) begin
            if (f_err != ERR_NONE)   f_st = ST_ERROR;
            else if (f_halt)         f_st = ST_HALTED;
            else if (f_pe)           f_st = ST_PAST_END;
            else if (f_npc >= r_len) f_st = ST_PAST_END;
            else                     f_st = ST_RUNNING;
            if (f_st == ST_RUNNING) begin
                n_pc = f_npc;
            end else begin
                n_run = 1'b0;
                n_pc  = '0;
            end
            n_ov    = 1'b1;
            n_onpc  = (f_st == ST_RUNNING) ? f_npc : '0;
            n_ost   = f_st;
            n_oerr  = f_err;
            n_opv   = f_pv;
            n_oval  = f_pval;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= 1'b0;
            r_pc    <= '0;
            r_len   <= '0;
            r_cc    <= '0;
            r_hw    <= '0;
            r_regs  <= '{default: '0};
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_pc    <= n_pc;
            r_len   <= n_len;
            r_cc    <= n_cc;
            r_hw    <= n_hw;
            r_regs  <= n_regs;
            r_ov    <= n_ov;
        end
        r_cmd  <= n_cmd;
        r_a    <= n_a;
        r_bneg <= n_bneg;
        r_bq   <= n_bq;
        r_cv   <= n_cv;
        r_x    <= n_x;
        r_y    <= n_y;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_cnt  <= n_cnt;
        r_addr <= n_addr;
        r_rdz  <= n_rdz;
        r_onpc <= n_onpc;
        r_ost  <= n_ost;
        r_oerr <= n_oerr;
        r_opv  <= n_opv;
        r_oval <= n_oval;
    end

    assign i_item.ready         = (r_state == S_IDLE) && !r_ov;
    assign o_result.valid       = r_ov;
    assign o_result.next_pc     = r_onpc;
    assign o_result.run_status  = r_ost;
    assign o_result.error_code  = r_oerr;
    assign o_result.print_valid = r_opv;
    assign o_result.print_value = r_oval;
endmodule

`default_nettype wire

@@ design/sbe_ram.sv @@
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbe_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

@@ design/sbe_checker.sv @@
// ----------------------------------------------------------------------------
// sbe_checker
// Port-level checks on the result items of the bytecode executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbe_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic [sbe_pkg::PC_W-1:0]    i_next_pc,
    input wire logic [1:0]                  i_run_status,
    input wire logic [3:0]                  i_error_code,
    input wire logic                        i_print_valid,
    input wire logic [sbe_pkg::WORD_W-1:0]  i_print_value
);
    import sbe_pkg::*;

    a_err_iff_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_run_status == ST_ERROR) == (i_error_code != ERR_NONE)))
        else $error("error code disagrees with run status");

    a_end_pc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_run_status != ST_RUNNING) |-> (i_next_pc == '0))
        else $error("ended run reports nonzero next pc");

    a_print_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_print_valid) |-> (i_print_value == '0))
        else $error("print value without print");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item taken while previous still executing");
endmodule

bind stack_bytecode_executor_core sbe_checker u_sbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_next_pc    (o_result.next_pc),
    .i_run_status (o_result.run_status),
    .i_error_code (o_result.error_code),
    .i_print_valid(o_result.print_valid),
    .i_print_value(o_result.print_value)
);

`default_nettype wire
